>>> rtl/sas_pkg.sv
// Shared types and constants for the shell argument splitter.
// No dependencies; every module in rtl/ imports this package, the interfaces do not.
package sas_pkg;

   // Line and slot limits that clamp the capacity registers
   localparam int unsigned LineMax = 4096;
   localparam int unsigned ArgsMax = 256;

   // Result queue depth; two entries are kept free for an end-of-line request
   localparam int unsigned ResultDepth = 4;
   localparam int unsigned ResultPtrWidth = $clog2(ResultDepth);
   localparam int unsigned ResultCntWidth = $clog2(ResultDepth + 1);

   // Character codes
   localparam logic [7:0] CharSpace   = 8'h20;
   localparam logic [7:0] CharTab     = 8'h09;
   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharDquote  = 8'h22;
   localparam logic [7:0] CharBslash  = 8'h5c;
   localparam logic [7:0] CharSquote  = 8'h27;

   // Register map (byte address = 4 * index)
   typedef enum logic [1:0] {
      CsrBufferCapacity = 2'd0,
      CsrArgsCapacity   = 2'd1,
      CsrCountOnly      = 2'd2
   } sas_csr_index_type;

   typedef enum logic [2:0] {
      PhaseBetween = 3'd0,
      PhaseArg     = 3'd1,
      PhaseEscape  = 3'd2,
      PhaseStrong  = 3'd3,
      PhaseError   = 3'd4
   } sas_phase_type;

   typedef enum logic [2:0] {
      StatusOk     = 3'd0,
      StatusBuffer = 3'd1,
      StatusSlots  = 3'd2,
      StatusQuote  = 3'd3,
      StatusEscape = 3'd4
   } sas_status_type;

   typedef struct packed {
      logic [12:0] buffer_capacity;
      logic [8:0]  args_capacity;
      logic        count_only;
   } sas_cfg_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [7:0]  arg_index;
      logic        arg_end;
      logic        done_res;
      logic [2:0]  status;
      logic [8:0]  slot_count;
      logic [12:0] used_length;
      logic [11:0] error_position;
      logic        last;
   } sas_result_type;

   // Push from the tokenizer into the result queue
   typedef struct packed {
      logic [1:0]     count;
      sas_result_type first;
      sas_result_type second;
   } sas_push_type;

endpackage

>>> rtl/sas_req_if.sv
// Request channel: one command-line byte or an end-of-line mark.
// No dependencies.
interface sas_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_line;

   modport source (output valid, output char_byte, output end_of_line, input ready);
   modport sink (input valid, input char_byte, input end_of_line, output ready);
endinterface

>>> rtl/sas_rsp_if.sv
// Result channel: argument bytes, terminators and the line status.
// No dependencies.
interface sas_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic [7:0]  arg_index;
   logic        arg_end;
   logic        done_res;
   logic [2:0]  status;
   logic [8:0]  slot_count;
   logic [12:0] used_length;
   logic [11:0] error_position;
   logic        last;

   modport source (output valid, output out_byte, output byte_valid, output arg_index,
                   output arg_end, output done_res, output status, output slot_count,
                   output used_length, output error_position, output last, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input arg_index,
                 input arg_end, input done_res, input status, input slot_count,
                 input used_length, input error_position, input last, output ready);
endinterface

>>> rtl/sas_csr.sv
// Configuration registers behind the APB-style port.
// Depends on sas_pkg.
module sas_csr import sas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output sas_cfg_type cfg
);

   logic [12:0] buffer_capacity_ff;
   logic [8:0]  args_capacity_ff;
   logic        count_only_ff;
   logic        wr_en;
   sas_csr_index_type index;

   assign pready = 1'b1;
   assign index  = sas_csr_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;

   // Write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_capacity_ff <= 13'd4096;
         args_capacity_ff   <= 9'd256;
         count_only_ff      <= 1'b0;
      end else if (wr_en) begin
         case (index)
            CsrBufferCapacity: buffer_capacity_ff <= pwdata[12:0];
            CsrArgsCapacity:   args_capacity_ff   <= pwdata[8:0];
            CsrCountOnly:      count_only_ff      <= pwdata[0];
            default:           ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (index)
         CsrBufferCapacity: prdata = {19'd0, buffer_capacity_ff};
         CsrArgsCapacity:   prdata = {23'd0, args_capacity_ff};
         CsrCountOnly:      prdata = {31'd0, count_only_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign cfg.buffer_capacity = buffer_capacity_ff;
   assign cfg.args_capacity   = args_capacity_ff;
   assign cfg.count_only      = count_only_ff;

endmodule

>>> rtl/sas_core.sv
// Tokenizer: request register, line state and the per-byte decision logic.
// Depends on sas_pkg and sas_req_if; pushes its results into sas_fifo.
module sas_core import sas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sas_req_if.sink      req,
   input  sas_cfg_type  cfg,
   input  logic         space_ok,
   output sas_push_type push
);

   logic          in_valid_ff;
   logic [7:0]    char_ff;
   logic          eol_ff;
   logic          advance;

   sas_phase_type phase_ff, phase_in;
   logic          weak_ff, weak_in;
   logic [12:0]   wc_ff, wc_in;
   logic [8:0]    ac_ff, ac_in;
   logic [11:0]   cpos_ff, cpos_in;
   logic [11:0]   qpos_ff, qpos_in;
   sas_status_type err_ff, err_in;

   logic [12:0]   buf_cap;
   logic [8:0]    slot_cap;
   logic          co;
   logic          is_sp;

   assign advance   = in_valid_ff && space_ok;
   assign req.ready = !reset && (!in_valid_ff || advance);

   // Clamp the capacities to the build limits
   assign buf_cap  = (32'(cfg.buffer_capacity) > LineMax) ? 13'(LineMax) : cfg.buffer_capacity;
   assign slot_cap = (32'(cfg.args_capacity) > ArgsMax) ? 9'(ArgsMax) : cfg.args_capacity;
   assign co       = cfg.count_only;
   assign is_sp    = (char_ff == CharSpace) || (char_ff == CharTab) || (char_ff == CharNewline);

   // Hold the request until the queue has room
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         char_ff <= req.char_byte;
         eol_ff  <= req.end_of_line;
      end
   end

   // Line state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseBetween;
         weak_ff  <= 1'b0;
         wc_ff    <= '0;
         ac_ff    <= '0;
         cpos_ff  <= '0;
         qpos_ff  <= '0;
         err_ff   <= StatusOk;
      end else if (advance) begin
         phase_ff <= phase_in;
         weak_ff  <= weak_in;
         wc_ff    <= wc_in;
         ac_ff    <= ac_in;
         cpos_ff  <= cpos_in;
         qpos_ff  <= qpos_in;
         err_ff   <= err_in;
      end
   end

   // Decide next state and results for the held request
   always_comb begin
      sas_phase_type  ph_eff;
      sas_phase_type  ph_target;
      sas_status_type st;
      sas_result_type res_byte;
      sas_result_type res_done;
      logic [8:0]     ac_eff;
      logic [12:0]    wc_fin;
      logic [11:0]    epos;
      logic           go;
      logic           want_emit;
      logic           strong_check;
      logic           term_out;
      logic [7:0]     emit_b;
      logic           emit_end;

      phase_in = phase_ff;
      weak_in  = weak_ff;
      wc_in    = wc_ff;
      ac_in    = ac_ff;
      cpos_in  = cpos_ff;
      qpos_in  = qpos_ff;
      err_in   = err_ff;

      ph_eff       = phase_ff;
      ph_target    = phase_ff;
      st           = StatusOk;
      res_byte     = '0;
      res_done     = '0;
      ac_eff       = ac_ff;
      wc_fin       = wc_ff;
      epos         = '0;
      go           = 1'b1;
      want_emit    = 1'b0;
      strong_check = 1'b0;
      term_out     = 1'b0;
      emit_b       = char_ff;
      emit_end     = 1'b0;
      push         = '0;

      if (eol_ff) begin
         // Close the line and report
         if (phase_ff == PhaseError) begin
            st = err_ff;
         end else if (!co && slot_cap == 9'd0) begin
            st = StatusSlots;
         end else if (phase_ff == PhaseEscape) begin
            st   = StatusEscape;
            epos = cpos_ff - 12'd1;
         end else if (phase_ff == PhaseStrong || (phase_ff == PhaseArg && weak_ff)) begin
            st   = StatusQuote;
            epos = qpos_ff;
         end else if (phase_ff == PhaseArg) begin
            if (co) begin
               wc_fin = (wc_ff == '1) ? wc_ff : wc_ff + 13'd1;
            end else if (wc_ff >= buf_cap) begin
               st = StatusBuffer;
            end else begin
               term_out           = 1'b1;
               wc_fin             = wc_ff + 13'd1;
               res_byte.byte_valid = 1'b1;
               res_byte.arg_end   = 1'b1;
               res_byte.arg_index = 8'(ac_ff - 9'd1);
            end
         end
         res_done.done_res = 1'b1;
         res_done.status   = st;
         res_done.last     = 1'b1;
         if (st == StatusOk) begin
            res_done.slot_count  = (ac_ff == '1) ? ac_ff : ac_ff + 9'd1;
            res_done.used_length = wc_fin;
         end
         if (st == StatusQuote || st == StatusEscape) begin
            res_done.error_position = epos;
         end
         if (term_out) begin
            push.count  = 2'd2;
            push.first  = res_byte;
            push.second = res_done;
         end else begin
            push.count = 2'd1;
            push.first = res_done;
         end
         phase_in = PhaseBetween;
         weak_in  = 1'b0;
         wc_in    = '0;
         ac_in    = '0;
         cpos_in  = '0;
         qpos_in  = '0;
         err_in   = StatusOk;
      end else begin
         // Open an argument on the first non-separator byte
         if (phase_ff == PhaseBetween) begin
            if (is_sp) begin
               go = 1'b0;
            end else if (!co && {1'b0, slot_cap} < {1'b0, ac_ff} + 10'd2) begin
               go       = 1'b0;
               phase_in = PhaseError;
               err_in   = StatusSlots;
            end else begin
               ac_eff = (ac_ff == '1) ? ac_ff : ac_ff + 9'd1;
               ph_eff = PhaseArg;
            end
         end
         ac_in = ac_eff;

         if (go) begin
            phase_in = ph_eff;
            case (ph_eff)
               PhaseArg: begin
                  if (char_ff == CharDquote) begin
                     qpos_in = cpos_ff;
                     weak_in = ~weak_ff;
                  end else if (char_ff == CharBslash) begin
                     phase_in = PhaseEscape;
                  end else if (is_sp && !weak_ff) begin
                     want_emit = 1'b1;
                     emit_end  = 1'b1;
                     ph_target = PhaseBetween;
                  end else if (char_ff == CharSquote && !weak_ff) begin
                     qpos_in = cpos_ff;
                     if (!co && wc_ff >= buf_cap) begin
                        phase_in = PhaseError;
                        err_in   = StatusBuffer;
                     end else begin
                        phase_in = PhaseStrong;
                     end
                  end else begin
                     want_emit = 1'b1;
                     ph_target = PhaseArg;
                  end
               end
               PhaseEscape: begin
                  want_emit = 1'b1;
                  ph_target = PhaseArg;
               end
               PhaseStrong: begin
                  if (char_ff == CharSquote) begin
                     phase_in = PhaseArg;
                  end else begin
                     want_emit    = 1'b1;
                     strong_check = 1'b1;
                     ph_target    = PhaseStrong;
                  end
               end
               default: ;
            endcase
         end

         // Write one byte or terminator
         if (want_emit) begin
            if (co) begin
               wc_in    = (wc_ff == '1) ? wc_ff : wc_ff + 13'd1;
               phase_in = ph_target;
            end else if (wc_ff >= buf_cap) begin
               phase_in = PhaseError;
               err_in   = StatusBuffer;
            end else begin
               wc_in               = wc_ff + 13'd1;
               phase_in            = ph_target;
               res_byte.out_byte   = emit_end ? 8'd0 : emit_b;
               res_byte.byte_valid = 1'b1;
               res_byte.arg_index  = 8'(ac_eff - 9'd1);
               res_byte.arg_end    = emit_end;
               res_byte.last       = 1'b1;
               push.count          = 2'd1;
               push.first          = res_byte;
               if (strong_check && (wc_ff + 13'd1) >= buf_cap) begin
                  phase_in = PhaseError;
                  err_in   = StatusBuffer;
               end
            end
         end
         cpos_in = cpos_ff + 12'd1;
      end

      // Drop the push unless the request advances
      if (!advance) begin
         push.count = 2'd0;
      end
   end

endmodule

>>> rtl/sas_fifo.sv
// Result queue: takes up to two results a cycle, drives the result channel.
// Depends on sas_pkg and sas_rsp_if.
module sas_fifo import sas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sas_push_type push,
   output logic         space_ok,
   sas_rsp_if.source    rsp
);

   sas_result_type                mem_ff [ResultDepth];
   logic [ResultPtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ResultPtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ResultCntWidth-1:0]     count_ff, count_in;
   logic [ResultPtrWidth-1:0]     wr_next;
   logic                          pop;
   sas_result_type                head;

   assign space_ok = (32'(count_ff) + 2 <= ResultDepth);
   assign pop      = rsp.valid && rsp.ready;
   assign wr_next  = wr_ptr_ff + ResultPtrWidth'(1);

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + ResultPtrWidth'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + ResultPtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + ResultCntWidth'(push.count) - ResultCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed results
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   assign head               = mem_ff[rd_ptr_ff];
   assign rsp.valid          = (count_ff != '0);
   assign rsp.out_byte       = head.out_byte;
   assign rsp.byte_valid     = head.byte_valid;
   assign rsp.arg_index      = head.arg_index;
   assign rsp.arg_end        = head.arg_end;
   assign rsp.done_res       = head.done_res;
   assign rsp.status         = head.status;
   assign rsp.slot_count     = head.slot_count;
   assign rsp.used_length    = head.used_length;
   assign rsp.error_position = head.error_position;
   assign rsp.last           = head.last;

endmodule

>>> rtl/shell_arg_splitter_unit.sv
// Shell-style command line splitter, top level.
// Depends on sas_pkg, sas_req_if, sas_rsp_if, sas_csr, sas_core, sas_fifo.
//
//   channel   direction  handshake                     carries
//   req_chan  in         valid/ready                   char_byte, end_of_line
//   rsp_chan  out        valid/ready                   byte or terminator, or status
//   csr       in         psel/penable/pwrite, pready=1 capacities, count-only flag
//
// One request a cycle: a byte request yields at most one result, so the rate is
// one per cycle while the result side keeps up; an end-of-line request yields up
// to two results, which the single-result output port drains one at a time.
// A request waits in the request register until the queue has room for two results,
// then its results are written into the four-entry result queue, whose head shows.
// Synchronous reset clears the line state and empties the queue; no clearing pass.
// A stalled result side fills the queue, then holds the request register and ready.
module shell_arg_splitter_unit import sas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sas_req_if.sink     req_chan,
   sas_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   sas_cfg_type  cfg;
   sas_push_type push;
   logic         space_ok;

   sas_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sas_core u_core (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .cfg      (cfg),
      .space_ok (space_ok),
      .push     (push)
   );

   sas_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_chan)
   );

endmodule

>>> rtl/sas_checker.sv
// Port-level checks for the splitter's result channel, bound to the top level.
// Depends on sas_pkg and shell_arg_splitter_unit.
module sas_checker import sas_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_arg_end,
   input logic        rsp_done_res,
   input logic [2:0]  rsp_status,
   input logic [8:0]  rsp_slot_count,
   input logic [12:0] rsp_used_length,
   input logic        rsp_last
);

   // Queue is empty the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result changed");

   // Status closes the request's results and carries no byte
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_byte_valid && rsp_last)
      else $error("status result malformed");

   // Terminator is a zero byte and is not a status
   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arg_end |-> rsp_byte_valid && rsp_out_byte == 8'd0 && !rsp_done_res)
      else $error("terminator malformed");

   // Failure reports no sizes
   a_fail_sizes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status != StatusOk |->
         rsp_slot_count == 9'd0 && rsp_used_length == 13'd0)
      else $error("sizes on failed line");

endmodule

bind shell_arg_splitter_unit sas_checker u_sas_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_byte_valid  (rsp_chan.byte_valid),
   .rsp_arg_end     (rsp_chan.arg_end),
   .rsp_done_res    (rsp_chan.done_res),
   .rsp_status      (rsp_chan.status),
   .rsp_slot_count  (rsp_chan.slot_count),
   .rsp_used_length (rsp_chan.used_length),
   .rsp_last        (rsp_chan.last)
);

>>> dv/shell_arg_splitter_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for shell_arg_splitter_unit: directed rows, random command lines, then a full-slot line.
// Depends on sas_pkg, sas_req_if, sas_rsp_if and the block itself.
module shell_arg_splitter_unit_tb;
   import sas_pkg::*;

   typedef enum logic [1:0] {
      RowChar = 2'd0,
      RowEnd  = 2'd1,
      RowCsr  = 2'd2
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [12:0]       value;
      sas_csr_index_type csr;
      bit                typed;
      sas_result_type    status_res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel, penable, pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   sas_req_if req_chan ();
   sas_rsp_if rsp_chan ();

   shell_arg_splitter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: configuration and line state
   logic [12:0]    cfg_buf;
   logic [8:0]     cfg_args;
   logic           cfg_count_only;
   sas_phase_type  ln_phase;
   logic           weak_on;
   logic [12:0]    wr_count;
   logic [8:0]     ar_count;
   logic [11:0]    ch_pos;
   logic [11:0]    q_pos;
   sas_status_type err_code;

   sas_result_type step_results[$];
   sas_result_type split_out_q[$];
   stim_row_type   stim_table[$];
   logic [7:0]     line_bytes[$];

   // Typed expectation travels with the request it belongs to
   logic           row_typed;
   sas_result_type row_expect;

   int unsigned mismatch_count = 0;
   bit          calm_in = 1'b0;
   int unsigned out_stall = 0;
   int unsigned out_calm = 0;

   function automatic bit is_sep(logic [7:0] c);
      return c == CharSpace || c == CharTab || c == CharNewline;
   endfunction

   function automatic int unsigned buf_limit();
      return (cfg_buf < LineMax) ? int'(cfg_buf) : LineMax;
   endfunction

   function automatic int unsigned slot_limit();
      return (cfg_args < ArgsMax) ? int'(cfg_args) : ArgsMax;
   endfunction

   function automatic void clear_line();
      ln_phase = PhaseBetween;
      weak_on  = 1'b0;
      wr_count = '0;
      ar_count = '0;
      ch_pos   = '0;
      q_pos    = '0;
      err_code = StatusOk;
   endfunction

   function automatic void fail_line(sas_status_type st);
      ln_phase = PhaseError;
      err_code = st;
   endfunction

   // Write one argument byte or terminator, or trip the buffer limit
   function automatic void write_out(logic [7:0] b, logic aend);
      sas_result_type r;
      if (cfg_count_only) begin
         if (wr_count < 13'h1fff) wr_count++;
         return;
      end
      if (wr_count >= buf_limit()) begin
         fail_line(StatusBuffer);
         return;
      end
      r = '0;
      r.out_byte   = aend ? 8'h00 : b;
      r.byte_valid = 1'b1;
      r.arg_index  = 8'(ar_count - 9'd1);
      r.arg_end    = aend;
      step_results.push_back(r);
      wr_count++;
   endfunction

   function automatic void take_char(logic [7:0] c);
      logic [11:0] pos;
      pos = ch_pos;
      // Open a new argument on the first non-separator
      if (ln_phase == PhaseBetween) begin
         if (is_sep(c)) return;
         if (!cfg_count_only && slot_limit() < ar_count + 2) begin
            fail_line(StatusSlots);
            return;
         end
         if (ar_count < 9'h1ff) ar_count++;
         ln_phase = PhaseArg;
      end
      case (ln_phase)
         PhaseArg: begin
            if (c == CharDquote) begin
               q_pos = pos;
               weak_on = ~weak_on;
            end else if (c == CharBslash) begin
               ln_phase = PhaseEscape;
            end else if (is_sep(c) && !weak_on) begin
               write_out(8'h00, 1'b1);
               if (ln_phase != PhaseError) ln_phase = PhaseBetween;
            end else if (c == CharSquote && !weak_on) begin
               q_pos = pos;
               if (!cfg_count_only && wr_count >= buf_limit()) fail_line(StatusBuffer);
               else ln_phase = PhaseStrong;
            end else begin
               write_out(c, 1'b0);
            end
         end
         PhaseEscape: begin
            write_out(c, 1'b0);
            if (ln_phase != PhaseError) ln_phase = PhaseArg;
         end
         PhaseStrong: begin
            if (c == CharSquote) begin
               ln_phase = PhaseArg;
            end else begin
               write_out(c, 1'b0);
               // A strong quote that fills the buffer fails at once
               if (ln_phase != PhaseError && !cfg_count_only && wr_count >= buf_limit())
                  fail_line(StatusBuffer);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void end_line();
      sas_status_type st;
      logic [11:0]    epos;
      sas_result_type r;
      st = StatusOk;
      epos = '0;
      if (ln_phase == PhaseError) begin
         st = err_code;
      end else if (!cfg_count_only && slot_limit() == 0) begin
         st = StatusSlots;
      end else if (ln_phase == PhaseEscape) begin
         st = StatusEscape;
         epos = ch_pos - 12'd1;
      end else if (ln_phase == PhaseStrong || (ln_phase == PhaseArg && weak_on)) begin
         st = StatusQuote;
         epos = q_pos;
      end else if (ln_phase == PhaseArg) begin
         write_out(8'h00, 1'b1);
         if (ln_phase == PhaseError) st = err_code;
      end
      r = '0;
      r.done_res = 1'b1;
      r.status = st;
      if (st == StatusQuote || st == StatusEscape) begin
         r.error_position = epos;
      end else if (st == StatusOk) begin
         r.slot_count = (ar_count < 9'h1ff) ? ar_count + 9'd1 : 9'h1ff;
         r.used_length = wr_count;
      end
      step_results.push_back(r);
      clear_line();
   endfunction

   // Predict the results of one accepted request into step_results
   function automatic void split_step(logic [7:0] c, logic eol);
      step_results.delete();
      if (eol) begin
         end_line();
      end else begin
         take_char(c);
         ch_pos = ch_pos + 12'd1;
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
   endfunction

   function automatic sas_result_type line_status(sas_status_type st, int unsigned slots,
                                                  int unsigned used, int unsigned epos);
      sas_result_type r;
      r = '0;
      r.done_res = 1'b1;
      r.status = st;
      r.slot_count = 9'(slots);
      r.used_length = 13'(used);
      r.error_position = 12'(epos);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Predict on each accepted request, check each accepted result
   sas_result_type want;
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         split_step(req_chan.char_byte, req_chan.end_of_line);
         if (row_typed) step_results[step_results.size() - 1] = row_expect;
         foreach (step_results[i]) split_out_q.push_back(step_results[i]);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (split_out_q.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual byte %0d status %0d",
                     $time, rsp_chan.out_byte, rsp_chan.status);
            mismatch_count++;
         end else begin
            want = split_out_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("byte_valid", want.byte_valid, rsp_chan.byte_valid);
            check_field("arg_index", want.arg_index, rsp_chan.arg_index);
            check_field("arg_end", want.arg_end, rsp_chan.arg_end);
            check_field("done_res", want.done_res, rsp_chan.done_res);
            check_field("status", want.status, rsp_chan.status);
            check_field("slot_count", want.slot_count, rsp_chan.slot_count);
            check_field("used_length", want.used_length, rsp_chan.used_length);
            check_field("error_position", want.error_position, rsp_chan.error_position);
            check_field("last", want.last, rsp_chan.last);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      else if (r < 95) return $urandom_range(3, 8);
      else return $urandom_range(15, 40);
   endfunction

   // Result side: short and long stalls, with calm stretches in between
   always @(posedge clock) begin
      if (out_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         out_stall <= out_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (out_calm > 0) begin
            out_calm <= out_calm - 1;
         end else begin
            case ($urandom_range(0, 19))
               0: out_calm <= $urandom_range(50, 200);
               1, 2, 3, 4, 5, 6: out_stall <= pick_gap();
               default: ;
            endcase
         end
      end
   end

   // Drive one request and hold it until accepted, then maybe idle
   task automatic send_request(logic [7:0] c, logic eol, bit typed, sas_result_type fixed);
      int unsigned gap;
      req_chan.valid <= 1'b1;
      req_chan.char_byte <= c;
      req_chan.end_of_line <= eol;
      row_typed <= typed;
      row_expect <= fixed;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (!calm_in && $urandom_range(0, 9) < 3) begin
         gap = pick_gap();
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (split_out_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(sas_csr_index_type idx, logic [12:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {19'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CsrBufferCapacity: cfg_buf = val;
         CsrArgsCapacity:   cfg_args = val[8:0];
         CsrCountOnly:      cfg_count_only = val[0];
         default: ;
      endcase
   endtask

   function automatic void add_byte(logic [7:0] c);
      stim_table.push_back('{RowChar, {5'd0, c}, CsrBufferCapacity, 1'b0, '0});
   endfunction

   function automatic void add_end_line();
      stim_table.push_back('{RowEnd, 13'd0, CsrBufferCapacity, 1'b0, '0});
   endfunction

   function automatic void add_end_status(sas_result_type res);
      stim_table.push_back('{RowEnd, 13'd0, CsrBufferCapacity, 1'b1, res});
   endfunction

   function automatic void add_csr(sas_csr_index_type idx, logic [12:0] val);
      stim_table.push_back('{RowCsr, val, idx, 1'b0, '0});
   endfunction

   function automatic void build_directed();
      // Empty line right after reset
      add_end_status(line_status(StatusOk, 1, 0, 0));
      // Plain bytes, 0xff and a zero byte as data
      add_byte(8'h61); add_byte(CharSpace); add_byte(8'hff); add_byte(8'h00);
      add_end_line();
      // Weak quote keeps a tab, escaped quote, strong quote keeps a newline
      add_byte(CharDquote); add_byte(CharTab); add_byte(CharBslash); add_byte(CharDquote);
      add_byte(CharDquote); add_byte(CharSquote); add_byte(CharNewline); add_byte(CharSquote);
      add_end_line();
      // Lonely escape and an unmatched quote
      add_byte(CharBslash);
      add_end_status(line_status(StatusEscape, 0, 0, 0));
      add_byte(CharSquote); add_byte(8'h71);
      add_end_status(line_status(StatusQuote, 0, 0, 0));
      // Strong quote filling the buffer fails even though it closes
      add_csr(CsrBufferCapacity, 13'd2);
      add_byte(CharSquote); add_byte(8'h61); add_byte(8'h62); add_byte(CharSquote);
      add_end_status(line_status(StatusBuffer, 0, 0, 0));
      // No slot at all, buffer above the line limit
      add_csr(CsrBufferCapacity, 13'h1fff);
      add_csr(CsrArgsCapacity, 13'd0);
      add_end_status(line_status(StatusSlots, 0, 0, 0));
      // Count-only ignores the slot limit
      add_csr(CsrArgsCapacity, 13'd2);
      add_csr(CsrCountOnly, 13'd1);
      add_byte(8'h61); add_byte(CharSpace); add_byte(8'h62);
      add_end_status(line_status(StatusOk, 3, 4, 0));
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(33, 126));
      end while (is_sep(c) || c == CharDquote || c == CharBslash || c == CharSquote);
      return c;
   endfunction

   function automatic logic [7:0] sep_char();
      case ($urandom_range(0, 2))
         0: return CharSpace;
         1: return CharTab;
         default: return CharNewline;
      endcase
   endfunction

   // Build a mostly well-formed command line, sometimes broken or noisy
   function automatic void build_line();
      int unsigned words, segs, n;
      logic [7:0]  c;
      line_bytes.delete();
      if ($urandom_range(0, 3) == 0) line_bytes.push_back(sep_char());
      words = $urandom_range(0, 5);
      for (int w = 0; w < words; w++) begin
         if (w > 0) begin
            n = $urandom_range(1, 2);
            repeat (n) line_bytes.push_back(sep_char());
         end
         segs = $urandom_range(1, 3);
         repeat (segs) begin
            case ($urandom_range(0, 5))
               3: begin
                  line_bytes.push_back(CharDquote);
                  n = $urandom_range(0, 4);
                  repeat (n) begin
                     case ($urandom_range(0, 3))
                        0: line_bytes.push_back(sep_char());
                        1: line_bytes.push_back(CharSquote);
                        2: begin
                           line_bytes.push_back(CharBslash);
                           line_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                        default: line_bytes.push_back(plain_char());
                     endcase
                  end
                  line_bytes.push_back(CharDquote);
               end
               4: begin
                  line_bytes.push_back(CharSquote);
                  n = $urandom_range(0, 5);
                  repeat (n) begin
                     do c = 8'($urandom_range(0, 255)); while (c == CharSquote);
                     line_bytes.push_back(c);
                  end
                  line_bytes.push_back(CharSquote);
               end
               5: begin
                  line_bytes.push_back(CharBslash);
                  line_bytes.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  n = $urandom_range(1, 4);
                  repeat (n) line_bytes.push_back(plain_char());
               end
            endcase
         end
      end
      if ($urandom_range(0, 3) == 0) line_bytes.push_back(sep_char());
      // Break or pollute a share of the lines
      case ($urandom_range(0, 19))
         0: line_bytes.push_back(CharBslash);
         1: begin
            line_bytes.push_back(CharDquote);
            line_bytes.push_back(plain_char());
         end
         2: begin
            line_bytes.push_back(CharSquote);
            line_bytes.push_back(plain_char());
         end
         3, 4: begin
            n = $urandom_range(1, 6);
            repeat (n)
               line_bytes.insert($urandom_range(0, line_bytes.size()),
                                 8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endfunction

   task automatic send_line();
      foreach (line_bytes[i]) send_request(line_bytes[i], 1'b0, 1'b0, '0);
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
   endtask

   initial begin : stimulus
      int unsigned sent, phase_start, phase_len;
      logic [12:0] buf_val, args_val;

      // Hold every input at a known value through reset
      req_chan.valid = 1'b0;
      req_chan.char_byte = 8'h00;
      req_chan.end_of_line = 1'b0;
      rsp_chan.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      row_typed = 1'b0;
      row_expect = '0;
      cfg_buf = 13'd4096;
      cfg_args = 9'd256;
      cfg_count_only = 1'b0;
      clear_line();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      build_directed();
      foreach (stim_table[i]) begin
         case (stim_table[i].kind)
            RowCsr: begin
               drain_results();
               write_csr(stim_table[i].csr, stim_table[i].value);
            end
            RowChar: send_request(stim_table[i].value[7:0], 1'b0, 1'b0, '0);
            default: send_request(8'($urandom_range(0, 255)), 1'b1, stim_table[i].typed,
                                  stim_table[i].status_res);
         endcase
      end

      // Random phases, each with its own register setting
      sent = 0;
      while (sent < 1000) begin
         drain_results();
         case ($urandom_range(0, 5))
            0: buf_val = 13'd0;
            1: buf_val = 13'($urandom_range(1, 6));
            2: buf_val = 13'($urandom_range(7, 40));
            3: buf_val = 13'd4096;
            4: buf_val = 13'($urandom_range(4097, 8191));
            default: buf_val = 13'($urandom_range(0, 8191));
         endcase
         case ($urandom_range(0, 5))
            0: args_val = 13'd0;
            1: args_val = 13'($urandom_range(1, 4));
            2: args_val = 13'($urandom_range(5, 12));
            3: args_val = 13'd256;
            4: args_val = 13'($urandom_range(257, 511));
            default: args_val = 13'($urandom_range(0, 511));
         endcase
         write_csr(CsrBufferCapacity, buf_val);
         write_csr(CsrArgsCapacity, args_val);
         write_csr(CsrCountOnly, 13'($urandom_range(0, 3) == 0));
         phase_len = $urandom_range(30, 100);
         phase_start = sent;
         while (sent - phase_start < phase_len) begin
            build_line();
            calm_in = ($urandom_range(0, 4) == 0);
            send_line();
            sent += line_bytes.size() + 1;
         end
      end

      // Fill every slot: 255 one-byte arguments at full capacity
      drain_results();
      write_csr(CsrBufferCapacity, 13'd4096);
      write_csr(CsrArgsCapacity, 13'd256);
      write_csr(CsrCountOnly, 13'd0);
      line_bytes.delete();
      repeat (255) begin
         line_bytes.push_back(plain_char());
         line_bytes.push_back(sep_char());
      end
      calm_in = 1'b0;
      send_line();

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("shell_arg_splitter_unit: match");
      end else begin
         $display("shell_arg_splitter_unit: mismatch");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #12_000_000;
      $display("shell_arg_splitter_unit: mismatch");
      $finish;
   end

endmodule
